>>> design/ssm_pkg.sv
// Shared widths, defaults and command codes for the int8 state-space step block.
package ssm_pkg;

  localparam int CHANNELS_DEF   = 16;
  localparam int STATE_SIZE_DEF = 16;

  localparam int CMD_W     = 3;
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 8;
  // Wide enough to hold any parameter value of CHANNELS or STATE_SIZE (up to 127).
  localparam int IDX_EXT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP    = 3'd0,
    CMD_WRITE_A = 3'd1,
    CMD_WRITE_B = 3'd2,
    CMD_WRITE_C = 3'd3,
    CMD_WRITE_D = 3'd4
  } cmd_t;

endpackage

>>> design/ssm_if.sv
// Valid/ready channel interfaces for the command items and the channel results.
interface ssm_req_if;
  logic                                     valid;
  logic                                     ready;
  logic        [ssm_pkg::CMD_W-1:0]         cmd;
  logic        [ssm_pkg::IDX_W-1:0]         row;
  logic        [ssm_pkg::IDX_W-1:0]         col;
  logic signed [ssm_pkg::DATA_W-1:0]        weight;
  logic signed [ssm_pkg::DATA_W-1:0]        sample;

  modport source (output valid, cmd, row, col, weight, sample, input ready);
  modport sink   (input valid, cmd, row, col, weight, sample, output ready);
endinterface

interface ssm_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic        [ssm_pkg::IDX_W-1:0]         channel;
  logic signed [ssm_pkg::DATA_W-1:0]        y_value;
  logic                                     last;

  modport source (output valid, channel, y_value, last, input ready);
  modport sink   (input valid, channel, y_value, last, output ready);
endinterface

>>> design/int8_state_space_model_step_top.sv
// Int8 state-space step engine on one shared multiplier; load beats are taken only while idle.
// Load beats (write A, B, C or D) give no result. A step beat keeps ready low until its
// last row closes, including any time that a row waits for the result register to free:
// a fetch and five multiplier passes per state element and a closing S_ROW state per row.
// Reset clears all H_DEPTH entries of the hidden state (256 at 16 by 16) with ready low.
module int8_state_space_model_step_top #(
  parameter int CHANNELS   = ssm_pkg::CHANNELS_DEF,
  parameter int STATE_SIZE = ssm_pkg::STATE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic signed [ssm_pkg::DATA_W-1:0] cfg_write_data,
  ssm_req_if.sink                           req,
  ssm_rsp_if.source                         rsp
);

  // Counter and address widths. The hidden and A stores are addressed as {row, column},
  // so their depth is CHANNELS rows of a power-of-two stride.
  localparam int ROW_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COL_W   = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
  localparam int AW      = ROW_W + COL_W;
  localparam int H_DEPTH = CHANNELS << COL_W;
  // The row accumulator holds STATE_SIZE products of at most 2**14 in magnitude.
  localparam int ACC_W   = 17 + $clog2(STATE_SIZE);
  localparam int EXT_W   = ssm_pkg::IDX_EXT_W;

  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(CHANNELS - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(STATE_SIZE - 1);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(H_DEPTH - 1);
  localparam logic [ssm_pkg::IDX_W-1:0] LAST_CHAN = ssm_pkg::IDX_W'(CHANNELS - 1);

  // Per-element sequence: fetch, dA, dB, dA*h, dB*x with update, C*h accumulate.
  // A row closes in S_ROW with the D*x term and the result load.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DA,
    S_DB,
    S_HMUL,
    S_HUPD,
    S_CACC,
    S_ROW
  } state_t;

  state_t                   state;
  logic [ROW_W-1:0]         d;
  logic [COL_W-1:0]         n;
  logic [AW-1:0]            clr_addr;

  logic signed [7:0]        dt;
  logic signed [7:0]        x;
  logic signed [9:0]        da;
  logic signed [9:0]        db;
  logic signed [19:0]       t;
  logic signed [7:0]        hn;
  logic signed [ACC_W-1:0]  acc;

  logic                     out_valid;
  logic [ssm_pkg::IDX_W-1:0] out_channel;
  logic signed [7:0]        out_y;
  logic                     out_last;
  logic                     row_load;

  // Weight and hidden stores, all read through registered ports.
  logic signed [7:0] a_mem [H_DEPTH];
  logic signed [7:0] h_mem [H_DEPTH];
  logic signed [7:0] b_mem [STATE_SIZE];
  logic signed [7:0] c_mem [STATE_SIZE];
  logic signed [7:0] d_mem [CHANNELS];
  logic signed [7:0] a_q, h_q, b_q, c_q, d_q;

  // Field decode for load beats. Indexes are widened so the range checks work for
  // any parameter value; writes that fall outside the array are dropped.
  logic [EXT_W-1:0] row_ext, col_ext;
  logic             row_ok, col_ok;
  logic             req_fire;
  logic [AW-1:0]    elem_addr;
  logic [AW-1:0]    load_addr;

  assign row_ext   = EXT_W'(req.row);
  assign col_ext   = EXT_W'(req.col);
  assign row_ok    = row_ext < EXT_W'(CHANNELS);
  assign col_ok    = col_ext < EXT_W'(STATE_SIZE);
  assign req_fire  = req.valid && req.ready;
  assign elem_addr = {d, n};
  assign load_addr = {row_ext[ROW_W-1:0], col_ext[COL_W-1:0]};

  assign req.ready = (state == S_IDLE);

  // The one shared multiplier; each sequencer state picks its operand pair.
  logic signed [8:0]  a_ext;
  logic signed [8:0]  a_mag;
  logic signed [9:0]  mul_a, mul_b;
  logic signed [19:0] prod;

  assign a_ext = 9'(a_q);
  assign a_mag = (a_ext < 0) ? -a_ext : a_ext;

  always_comb begin
    case (state)
      S_DA: begin
        mul_a = 10'(dt);
        mul_b = 10'(a_mag);
      end
      S_DB: begin
        mul_a = 10'(dt);
        mul_b = 10'(b_q);
      end
      S_HMUL: begin
        mul_a = da;
        mul_b = 10'(h_q);
      end
      S_HUPD: begin
        mul_a = db;
        mul_b = 10'(x);
      end
      S_CACC: begin
        mul_a = 10'(c_q);
        mul_b = 10'(hn);
      end
      S_ROW: begin
        mul_a = 10'(d_q);
        mul_b = 10'(x);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  function automatic logic signed [7:0] sat127(input logic signed [31:0] v);
    if (v > 32'sd127) begin
      return 8'sd127;
    end else if (v < -32'sd127) begin
      return -8'sd127;
    end
    return v[7:0];
  endfunction

  // Hidden update: floor shift of dA*h + dB*x, then saturation.
  logic signed [20:0] h_sum;
  logic signed [7:0]  h_new;
  logic signed [7:0]  y_new;

  assign h_sum = 21'(t) + 21'(prod);
  assign h_new = sat127(32'(h_sum >>> 7));
  assign y_new = sat127(32'(acc >>> 7) + 32'(prod >>> 7));

  // Hidden store write port: clearing pass after reset, else the element update.
  logic              h_we;
  logic [AW-1:0]     h_waddr;
  logic signed [7:0] h_wdata;

  always_comb begin
    h_we    = 1'b0;
    h_waddr = elem_addr;
    h_wdata = h_new;
    if (state == S_CLEAR) begin
      h_we    = 1'b1;
      h_waddr = clr_addr;
      h_wdata = '0;
    end else if (state == S_HUPD) begin
      h_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
    h_q <= h_mem[elem_addr];
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.cmd == ssm_pkg::CMD_WRITE_A && row_ok && col_ok) begin
      a_mem[load_addr] <= req.weight;
    end
    a_q <= a_mem[elem_addr];
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.cmd == ssm_pkg::CMD_WRITE_B && col_ok) begin
      b_mem[col_ext[COL_W-1:0]] <= req.weight;
    end
    b_q <= b_mem[n];
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.cmd == ssm_pkg::CMD_WRITE_C && col_ok) begin
      c_mem[col_ext[COL_W-1:0]] <= req.weight;
    end
    c_q <= c_mem[n];
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.cmd == ssm_pkg::CMD_WRITE_D && row_ok) begin
      d_mem[row_ext[ROW_W-1:0]] <= req.weight;
    end
    d_q <= d_mem[d];
  end

  // Time step scale: taken at any time; the user must change it only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= '0;
    end else if (cfg_write_en) begin
      dt <= cfg_write_data;
    end
  end

  // A row closes once the result register is free or is being emptied this cycle.
  assign row_load = (state == S_ROW) && (!out_valid || rsp.ready);

  // Sequencer, datapath registers and the result register. The result register
  // lets the next row run while the previous result beat waits to be taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      d         <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (row_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire && req.cmd == ssm_pkg::CMD_STEP) begin
            x     <= req.sample;
            d     <= '0;
            n     <= '0;
            acc   <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_DA;
        end
        S_DA: begin
          da    <= 10'(prod >>> 7);
          state <= S_DB;
        end
        S_DB: begin
          db    <= 10'(prod >>> 7);
          state <= S_HMUL;
        end
        S_HMUL: begin
          t     <= prod;
          state <= S_HUPD;
        end
        S_HUPD: begin
          hn    <= h_new;
          state <= S_CACC;
        end
        S_CACC: begin
          acc <= acc + ACC_W'(prod);
          if (n == LAST_COL) begin
            state <= S_ROW;
          end else begin
            n     <= n + 1'b1;
            state <= S_FETCH;
          end
        end
        S_ROW: begin
          if (row_load) begin
            out_channel <= ssm_pkg::IDX_W'(d);
            out_y       <= y_new;
            out_last    <= (d == LAST_ROW);
            acc         <= '0;
            n           <= '0;
            if (d == LAST_ROW) begin
              state <= S_IDLE;
            end else begin
              d     <= d + 1'b1;
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.channel = out_channel;
  assign rsp.y_value = out_y;
  assign rsp.last    = out_last;

`ifndef NO_ASSERTIONS
  // Every value written into the hidden store stays inside the saturation range.
  a_hidden_range: assert property (@(posedge clk) disable iff (rst)
    h_we |-> (h_wdata <= 8'sd127 && h_wdata >= -8'sd127))
    else $error("hidden state write outside -127..127");

  // A row only closes after its last state column has been accumulated.
  a_row_after_last_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW) |-> (n == LAST_COL))
    else $error("row closed before its last column");

  // The result flagged last belongs to the final channel row.
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last) |-> (rsp.channel == LAST_CHAN))
    else $error("last flag on a result that is not the final row");
`endif

endmodule

>>> dv/int8_state_space_model_step_top_tb.sv
// Self-checking testbench for the int8 state-space step block: loads, steps and time-step scales.
module int8_state_space_model_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block runs at its default size, so every 4-bit row and column index is in range.
  localparam int CH             = ssm_pkg::CHANNELS_DEF;
  localparam int ST             = ssm_pkg::STATE_SIZE_DEF;
  localparam int CMD_W          = ssm_pkg::CMD_W;
  localparam int IDX_W          = ssm_pkg::IDX_W;
  localparam int DATA_W         = ssm_pkg::DATA_W;
  localparam int FRAC_BITS      = 7;
  localparam int Y_MAX          = 127;
  localparam int Y_MIN          = -127;
  localparam int RESET_CYCLES   = 4;
  // Ample quiet time for a last load beat to finish before a register write.
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 64;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 25;
  // Slowest legal run is roughly 160 steps, each of whose 16 results may be held up by
  // receiver stalls, plus the clearing pass and the loads.
  localparam int LIMIT_CYCLES   = 2_000_000;

  typedef struct {
    logic        [CMD_W-1:0]  cmd;
    logic        [IDX_W-1:0]  row;
    logic        [IDX_W-1:0]  col;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] sample;
  } command_beat_t;

  typedef struct {
    logic        [IDX_W-1:0]  channel;
    logic signed [DATA_W-1:0] y_value;
    logic                     last;
  } row_output_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write_en;
  logic signed [DATA_W-1:0] cfg_write_data;

  ssm_req_if req_bus ();
  ssm_rsp_if rsp_bus ();

  int8_state_space_model_step_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .req           (req_bus),
    .rsp           (rsp_bus)
  );

  // Shadow copy of everything the block remembers: the scale register, the weights and
  // the hidden state. The weights are written in full before the first step is sent.
  logic signed [DATA_W-1:0] scale_shadow;
  logic signed [DATA_W-1:0] hidden_state [CH][ST];
  logic signed [DATA_W-1:0] a_matrix [CH][ST];
  logic signed [DATA_W-1:0] b_vector [ST];
  logic signed [DATA_W-1:0] c_vector [ST];
  logic signed [DATA_W-1:0] d_vector [CH];

  // Channel outputs that the block still owes, oldest first.
  row_output_t expected_rows [$];

  int mismatches;
  int cycle_count;
  int stall_left;
  bit req_gaps_on;
  bit rsp_stalls_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int clamp_y(int v);
    if (v > Y_MAX) return Y_MAX;
    if (v < Y_MIN) return Y_MIN;
    return v;
  endfunction

  // One step of the recurrence for sample x. Every right shift here is arithmetic on
  // a signed int, which rounds toward minus infinity as the block does.
  function automatic void step_recurrence(logic signed [DATA_W-1:0] x);
    int dt;
    int xv;
    int av;
    int mag;
    int da;
    int db;
    int hn;
    int acc;
    int y;
    row_output_t r;
    dt = scale_shadow;
    xv = x;
    for (int d = 0; d < CH; d++) begin
      acc = 0;
      for (int n = 0; n < ST; n++) begin
        av  = a_matrix[d][n];
        // A weight of -128 has magnitude 128, which needs the int width.
        mag = (av < 0) ? -av : av;
        da  = (dt * mag) >>> FRAC_BITS;
        db  = (dt * int'(b_vector[n])) >>> FRAC_BITS;
        hn  = clamp_y((da * int'(hidden_state[d][n]) + db * xv) >>> FRAC_BITS);
        hidden_state[d][n] = DATA_W'(hn);
        // The accumulator takes the freshly updated state.
        acc += int'(c_vector[n]) * hn;
      end
      y = clamp_y((acc >>> FRAC_BITS) + ((int'(d_vector[d]) * xv) >>> FRAC_BITS));
      r.channel = IDX_W'(d);
      r.y_value = DATA_W'(y);
      r.last    = (d == CH - 1);
      expected_rows.push_back(r);
    end
  endfunction

  // Applies one accepted beat to the shadow state. Loads and unknown codes give no output.
  function automatic void apply_command(command_beat_t b);
    case (b.cmd)
      ssm_pkg::CMD_STEP:    step_recurrence(b.sample);
      ssm_pkg::CMD_WRITE_A: a_matrix[b.row][b.col] = b.weight;
      ssm_pkg::CMD_WRITE_B: b_vector[b.col] = b.weight;
      ssm_pkg::CMD_WRITE_C: c_vector[b.col] = b.weight;
      ssm_pkg::CMD_WRITE_D: d_vector[b.row] = b.weight;
      default: ;
    endcase
  endfunction

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Signed bytes with the two extremes drawn more often than chance would give.
  function automatic logic signed [DATA_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DATA_W'(-128);
    if (r == 1) return DATA_W'(127);
    return DATA_W'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Sends one beat and updates the shadow state at the edge where it is taken. Valid is
  // only lowered for a gap or when idling, so back-to-back beats keep it high throughout.
  task automatic send_beat(command_beat_t b);
    int gap;
    gap = req_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.cmd    <= b.cmd;
    req_bus.row    <= b.row;
    req_bus.col    <= b.col;
    req_bus.weight <= b.weight;
    req_bus.sample <= b.sample;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    apply_command(b);
  endtask

  // The fields that a command does not use still carry random values.
  task automatic send_load(logic [CMD_W-1:0] cmd, int row, int col, int w);
    command_beat_t b;
    b.cmd    = cmd;
    b.row    = IDX_W'(row);
    b.col    = IDX_W'(col);
    b.weight = DATA_W'(w);
    b.sample = DATA_W'($urandom_range(0, 255));
    send_beat(b);
  endtask

  task automatic send_step(int x);
    command_beat_t b;
    b.cmd    = ssm_pkg::CMD_STEP;
    b.row    = IDX_W'($urandom_range(0, 15));
    b.col    = IDX_W'($urandom_range(0, 15));
    b.weight = DATA_W'($urandom_range(0, 255));
    b.sample = DATA_W'(x);
    send_beat(b);
  endtask

  task automatic send_unknown(int code);
    command_beat_t b;
    b.cmd    = CMD_W'(code);
    b.row    = IDX_W'($urandom_range(0, 15));
    b.col    = IDX_W'($urandom_range(0, 15));
    b.weight = DATA_W'($urandom_range(0, 255));
    b.sample = DATA_W'($urandom_range(0, 255));
    send_beat(b);
  endtask

  // Drops valid, waits for every owed output, then lets a last load beat finish.
  task automatic wait_until_idle();
    req_bus.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_time_step(int v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= DATA_W'(v);
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    scale_shadow = DATA_W'(v);
  endtask

  // Every weight is loaded before any step reads it. The scale is still at its reset
  // value of zero here, so the two steps see zero state and an output from D alone.
  task automatic test_weight_load();
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    for (int r = 0; r < CH; r++) begin
      for (int c = 0; c < ST; c++) begin
        send_load(ssm_pkg::CMD_WRITE_A, r, c, pick_byte());
      end
    end
    for (int c = 0; c < ST; c++) begin
      send_load(ssm_pkg::CMD_WRITE_B, $urandom_range(0, 15), c, pick_byte());
      send_load(ssm_pkg::CMD_WRITE_C, $urandom_range(0, 15), c, pick_byte());
    end
    for (int r = 0; r < CH; r++) begin
      send_load(ssm_pkg::CMD_WRITE_D, r, $urandom_range(0, 15), pick_byte());
    end
    send_step(127);
    send_step(-128);
    wait_until_idle();
  endtask

  // Corner weights, the unused command codes, and both extremes of the scale with
  // extreme samples, which drive the hidden state and the outputs into saturation.
  task automatic test_corners();
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    send_load(ssm_pkg::CMD_WRITE_A, 0, 0, -128);
    send_load(ssm_pkg::CMD_WRITE_A, CH - 1, ST - 1, 127);
    send_load(ssm_pkg::CMD_WRITE_B, $urandom_range(0, 15), 0, 127);
    send_load(ssm_pkg::CMD_WRITE_B, $urandom_range(0, 15), ST - 1, -128);
    send_load(ssm_pkg::CMD_WRITE_C, $urandom_range(0, 15), 0, 127);
    send_load(ssm_pkg::CMD_WRITE_C, $urandom_range(0, 15), ST - 1, -128);
    send_load(ssm_pkg::CMD_WRITE_D, 0, $urandom_range(0, 15), 127);
    send_load(ssm_pkg::CMD_WRITE_D, CH - 1, $urandom_range(0, 15), -128);
    for (int k = int'(ssm_pkg::CMD_WRITE_D) + 1; k < (1 << CMD_W); k++) begin
      send_unknown(k);
    end
    wait_until_idle();
    write_time_step(127);
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    send_step(127);
    send_step(127);
    send_step(-128);
    send_step(0);
    wait_until_idle();
    write_time_step(-128);
    send_step(-128);
    send_step(127);
    send_step(-1);
    wait_until_idle();
  endtask

  // Phases of random traffic, each under its own scale. Most of it is short bursts of
  // weight loads followed by steps; a few unknown codes are mixed in as noise.
  task automatic test_random_traffic();
    int scales [PHASES];
    int counted;
    int n_loads;
    int n_steps;
    scales = '{0, 1, -1, 127, -128, 0};
    scales[PHASES-1] = $urandom_range(0, 255);
    for (int p = 0; p < PHASES; p++) begin
      write_time_step(scales[p]);
      // The first phase runs with no idling at all on either side.
      req_gaps_on   = (p != 0) && ($urandom_range(0, 3) != 0);
      rsp_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 8) begin
          send_unknown($urandom_range(int'(ssm_pkg::CMD_WRITE_D) + 1, (1 << CMD_W) - 1));
        end else begin
          n_loads = $urandom_range(0, 3);
          n_steps = $urandom_range(1, 2);
          repeat (n_loads) begin
            send_load(CMD_W'($urandom_range(int'(ssm_pkg::CMD_WRITE_A),
                                            int'(ssm_pkg::CMD_WRITE_D))),
                      $urandom_range(0, 15), $urandom_range(0, 15), pick_byte());
            counted++;
          end
          repeat (n_steps) begin
            send_step(pick_byte());
            counted++;
          end
        end
      end
      wait_until_idle();
    end
  endtask

  // Output checker: each beat taken from the block is matched against the oldest owed
  // output. The ready level read here is the one set at the previous edge.
  always @(posedge clk) begin
    row_output_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("output beat for channel %0d with nothing owed",
                                  rsp_bus.channel));
      end else begin
        want = expected_rows.pop_front();
        if (rsp_bus.channel !== want.channel)
          report_mismatch($sformatf("channel %0d, expected %0d",
                                    rsp_bus.channel, want.channel));
        if (rsp_bus.y_value !== want.y_value)
          report_mismatch($sformatf("y_value %0d on channel %0d, expected %0d",
                                    rsp_bus.y_value, want.channel, want.y_value));
        if (rsp_bus.last !== want.last)
          report_mismatch($sformatf("last %b on channel %0d, expected %b",
                                    rsp_bus.last, want.channel, want.last));
      end
    end
  end

  // Receiver back-pressure: while stalls are enabled, ready drops at random for a
  // stretch whose length follows the same mostly-short distribution as the sender gaps.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    // The scale register resets to zero; hidden state resets to all zeros.
    scale_shadow  = '0;
    for (int d = 0; d < CH; d++) begin
      for (int n = 0; n < ST; n++) begin
        hidden_state[d][n] = '0;
      end
    end
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    req_bus.valid  <= 1'b0;
    req_bus.cmd    <= ssm_pkg::CMD_STEP;
    req_bus.row    <= '0;
    req_bus.col    <= '0;
    req_bus.weight <= '0;
    req_bus.sample <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // The block clears its hidden state after reset and holds ready low meanwhile;
    // the first beat simply waits for it.
    test_weight_load();
    test_corners();
    test_random_traffic();
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
design/ssm_pkg.sv
design/ssm_if.sv
design/int8_state_space_model_step_top.sv
dv/int8_state_space_model_step_top_tb.sv
